[rtl/core/fmc_pkg.sv]
package fmc_pkg;

    localparam int unsigned MODULUS       = 65521;
    localparam int unsigned CHECK_DIGITS  = 5;
    localparam int unsigned RES_W         = 16;
    // 2^16 mod 65521, used to fold the upper bits back into the residue
    localparam int unsigned FOLD          = (1 << RES_W) - MODULUS;
    localparam int unsigned SUM_W         = 2 * RES_W + 1;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_LOW_A = 8'd97;
    localparam logic [7:0] ASCII_LOW_D = 8'd100;
    localparam logic [3:0] HEX_A_VALUE = 4'd10;

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic [3:0]       seq;
        logic             ok;
    } chk_t;

    function automatic int unsigned pow10(input int unsigned n);
        int unsigned p;
        p = 1;
        for (int unsigned i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

endpackage

[rtl/core/fmc_in_if.sv]
interface fmc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

[rtl/core/fmc_out_if.sv]
interface fmc_out_if;
    logic       valid;
    logic       ready;
    logic       frame_valid;
    logic [3:0] sequence_digit;

    modport source (output valid, output frame_valid, output sequence_digit, input ready);
    modport sink   (input valid, input frame_valid, input sequence_digit, output ready);
endinterface

[rtl/core/frame_mod_checksum_checker.sv]
// channel   dir  payload                          beat
// chars     in   character[7:0], last_char        one frame character
// results   out  frame_valid, sequence_digit[3:0] one verdict per frame
//
// One character is taken every cycle unless a final character waits
// for the check stage; the residue step (x*16+d mod 65521) sits
// between the input register and the frame register. A verdict passes
// through the input, check, scaled-sum and fold-and-compare registers.
// Reset clears all valid flags and the frame state; stalls on results back
// up stage by stage, and chars stalls only behind a waiting final character.
module frame_mod_checksum_checker #(
    parameter int unsigned CHECK_DIGITS = fmc_pkg::CHECK_DIGITS
) (
    input  logic      clk,
    input  logic      rst_n,
    fmc_in_if.sink    chars,
    fmc_out_if.source results
);

    logic          chk_valid;
    logic          chk_ready;
    fmc_pkg::chk_t chk;
    logic [3:0]    digits [CHECK_DIGITS];

    fmc_front #(
        .CHECK_DIGITS (CHECK_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .chk_valid (chk_valid),
        .chk       (chk),
        .digits    (digits),
        .chk_ready (chk_ready)
    );

    fmc_check #(
        .CHECK_DIGITS (CHECK_DIGITS)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .chk_valid (chk_valid),
        .chk       (chk),
        .digits    (digits),
        .chk_ready (chk_ready),
        .results   (results)
    );

endmodule

[rtl/core/fmc_front.sv]
module fmc_front #(
    parameter int unsigned CHECK_DIGITS = fmc_pkg::CHECK_DIGITS
) (
    input  logic          clk,
    input  logic          rst_n,
    fmc_in_if.sink        chars,
    output logic          chk_valid,
    output fmc_pkg::chk_t chk,
    output logic [3:0]    digits [CHECK_DIGITS],
    input  logic          chk_ready
);

    localparam int unsigned CW = $clog2(CHECK_DIGITS + 2);
    localparam int unsigned RW = fmc_pkg::RES_W;

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_last_reg;

    logic [7:0]            delay_reg [CHECK_DIGITS];
    logic [7:0]            delay_next [CHECK_DIGITS];
    logic [RW-1:0]         residue_reg, residue_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  bad_reg, bad_next;
    logic [3:0]            front_digit_reg, front_digit_next;

    logic                  chk_valid_reg;
    fmc_pkg::chk_t         chk_reg, chk_next;
    logic [3:0]            digits_reg [CHECK_DIGITS];
    logic [3:0]            digits_next [CHECK_DIGITS];

    logic                  chk_free;
    logic                  adv;
    logic                  shift_out;
    logic                  head_dec, head_hex;
    logic [3:0]            head_val;
    logic [RW+3:0]         scaled;
    logic [RW:0]           folded;
    logic                  all_dec;
    logic                  count_full;

    assign chk_free    = !chk_valid_reg || chk_ready;
    assign adv         = in_valid_reg && (!in_last_reg || chk_free);
    assign chars.ready = !in_valid_reg || adv;
    assign chk_valid   = chk_valid_reg;
    assign chk         = chk_reg;
    assign digits      = digits_reg;

    always_comb
    begin
        shift_out = count_reg >= CW'(CHECK_DIGITS);
        head_dec  = delay_reg[0] >= fmc_pkg::ASCII_ZERO && delay_reg[0] <= fmc_pkg::ASCII_NINE;
        head_hex  = delay_reg[0] >= fmc_pkg::ASCII_LOW_A && delay_reg[0] <= fmc_pkg::ASCII_LOW_D;
        priority if (head_dec)
            head_val = 4'(delay_reg[0] - fmc_pkg::ASCII_ZERO);
        else if (head_hex)
            head_val = 4'(delay_reg[0] - fmc_pkg::ASCII_LOW_A) + fmc_pkg::HEX_A_VALUE;
        else
            head_val = 4'd0;

        // residue*16 + d, then fold the top nibble back and trim once
        scaled = {residue_reg, 4'b0000} + (RW+4)'(head_val);
        folded = (RW+1)'(scaled[RW+3:RW]) * (RW+1)'(fmc_pkg::FOLD) + (RW+1)'(scaled[RW-1:0]);

        residue_next     = residue_reg;
        bad_next         = bad_reg;
        front_digit_next = front_digit_reg;
        if (shift_out)
        begin
            if (folded >= (RW+1)'(fmc_pkg::MODULUS))
                residue_next = RW'(folded - (RW+1)'(fmc_pkg::MODULUS));
            else
                residue_next = RW'(folded);
            bad_next         = bad_reg || !(head_dec || head_hex);
            front_digit_next = head_val;
        end

        for (int unsigned i = 0; i + 1 < CHECK_DIGITS; i++)
        begin
            delay_next[i] = delay_reg[i + 1];
        end
        delay_next[CHECK_DIGITS - 1] = in_char_reg;

        if (count_reg < CW'(CHECK_DIGITS + 1))
            count_next = count_reg + CW'(1);
        else
            count_next = count_reg;
        count_full = count_next == CW'(CHECK_DIGITS + 1);

        all_dec = 1'b1;
        for (int unsigned i = 0; i < CHECK_DIGITS; i++)
        begin
            if (delay_next[i] >= fmc_pkg::ASCII_ZERO && delay_next[i] <= fmc_pkg::ASCII_NINE)
                digits_next[i] = 4'(delay_next[i] - fmc_pkg::ASCII_ZERO);
            else
            begin
                digits_next[i] = 4'd0;
                all_dec        = 1'b0;
            end
        end

        chk_next.residue = residue_next;
        chk_next.seq     = count_full ? front_digit_next : 4'd0;
        chk_next.ok      = count_full && !bad_next && all_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            chk_valid_reg   <= 1'b0;
            residue_reg     <= '0;
            count_reg       <= '0;
            bad_reg         <= 1'b0;
            front_digit_reg <= 4'd0;
            for (int unsigned i = 0; i < CHECK_DIGITS; i++)
            begin
                delay_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (chars.ready)
                in_valid_reg <= chars.valid;
            if (chk_free)
                chk_valid_reg <= adv && in_last_reg;
            if (adv)
            begin
                if (in_last_reg)
                begin
                    // frame done: start the next one from scratch
                    residue_reg     <= '0;
                    count_reg       <= '0;
                    bad_reg         <= 1'b0;
                    front_digit_reg <= 4'd0;
                    for (int unsigned i = 0; i < CHECK_DIGITS; i++)
                    begin
                        delay_reg[i] <= 8'd0;
                    end
                end
                else
                begin
                    residue_reg     <= residue_next;
                    count_reg       <= count_next;
                    bad_reg         <= bad_next;
                    front_digit_reg <= front_digit_next;
                    delay_reg       <= delay_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            in_char_reg <= chars.character;
            in_last_reg <= chars.last_char;
        end
        if (adv && in_last_reg && chk_free)
        begin
            chk_reg    <= chk_next;
            digits_reg <= digits_next;
        end
    end

endmodule

[rtl/core/fmc_check.sv]
module fmc_check #(
    parameter int unsigned CHECK_DIGITS = fmc_pkg::CHECK_DIGITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          chk_valid,
    input  fmc_pkg::chk_t chk,
    input  logic [3:0]    digits [CHECK_DIGITS],
    output logic          chk_ready,
    fmc_out_if.source     results
);

    localparam int unsigned RW   = fmc_pkg::RES_W;
    localparam int unsigned SW   = fmc_pkg::SUM_W;
    localparam int unsigned BW   = $clog2(fmc_pkg::pow10(CHECK_DIGITS));
    localparam int unsigned MULT = fmc_pkg::pow10(CHECK_DIGITS) % fmc_pkg::MODULUS;
    localparam int unsigned YW   = SW - RW + 5;

    logic          sum_valid_reg;
    logic [SW-1:0] sum_reg, sum_next;
    logic          sum_ok_reg;
    logic [3:0]    sum_seq_reg;

    logic          out_valid_reg;
    logic          frame_valid_reg, frame_valid_next;
    logic [3:0]    seq_reg;

    logic          out_free;
    logic          sum_free;
    logic [BW-1:0] back;
    logic [YW-1:0] fold1;
    logic [RW:0]   fold2;

    assign out_free  = !out_valid_reg || results.ready;
    assign sum_free  = !sum_valid_reg || out_free;
    assign chk_ready = sum_free;

    assign results.valid          = out_valid_reg;
    assign results.frame_valid    = frame_valid_reg;
    assign results.sequence_digit = seq_reg;

    // residue * (10^n mod p) + back
    always_comb
    begin
        back = '0;
        for (int unsigned i = 0; i < CHECK_DIGITS; i++)
        begin
            back = back + BW'(digits[i]) * BW'(fmc_pkg::pow10(CHECK_DIGITS - 1 - i));
        end
        sum_next = SW'(SW'(chk.residue) * SW'(MULT)) + SW'(back);
    end

    // two folds by 2^16 = 15 (mod p) leave a value below 2p
    always_comb
    begin
        fold1 = YW'(sum_reg[SW-1:RW]) * YW'(fmc_pkg::FOLD) + YW'(sum_reg[RW-1:0]);
        fold2 = (RW+1)'(fold1[YW-1:RW]) * (RW+1)'(fmc_pkg::FOLD) + (RW+1)'(fold1[RW-1:0]);
        frame_valid_next = sum_ok_reg
                           && (fold2 == '0 || fold2 == (RW+1)'(fmc_pkg::MODULUS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_free)
                sum_valid_reg <= chk_valid;
            if (out_free)
                out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_free && chk_valid)
        begin
            sum_reg     <= sum_next;
            sum_ok_reg  <= chk.ok;
            sum_seq_reg <= chk.seq;
        end
        if (out_free && sum_valid_reg)
        begin
            frame_valid_reg <= frame_valid_next;
            seq_reg         <= sum_seq_reg;
        end
    end

endmodule
